[rtl/sws_pkg.sv]
// Shared types, constants and the decay table of the sliding-window snippet scorer.
package sws_pkg;
	localparam int WindowDepth = 256;
	localparam int RingAw = $clog2(WindowDepth);
	localparam int NumTerms = 6;
	localparam int DecayEntries = 16;
	localparam int TableLen = 12;
	localparam int MaxTokens = 1048576;
	localparam int ScoreW = 40;
	localparam logic [ScoreW-1:0] ScoreMax = '1;

	localparam logic [2:0] CfgMaxWidth = 3'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DROP,
		ST_ADD,
		ST_SKIP,
		ST_OUT
	} state_t;

	// Contribution request to the shared multiply/accumulate unit.
	typedef struct packed {
		logic        go;
		logic        sub;
		logic [15:0] weight;
		logic [8:0]  count;
	} mac_req_t;

	function automatic logic [16:0] decay_lookup(input logic [8:0] count);
		logic [16:0] d;
		logic [8:0]  k;
		k = count - 9'd1;
		d = '0;
		if (count != 9'd0 && k < 9'(DecayEntries) && k < 9'(TableLen)) begin
			case (k[3:0])
				4'd0: d = 17'd65536;
				4'd1: d = 17'd24109;
				4'd2: d = 17'd8869;
				4'd3: d = 17'd3263;
				4'd4: d = 17'd1200;
				4'd5: d = 17'd442;
				4'd6: d = 17'd162;
				4'd7: d = 17'd60;
				4'd8: d = 17'd22;
				4'd9: d = 17'd8;
				4'd10: d = 17'd3;
				4'd11: d = 17'd1;
				default: d = 17'd0;
			endcase
		end
		return d;
	endfunction
endpackage

[rtl/sws_mac.sv]
// Shared multiply and saturating accumulate unit for the running score.
module sws_mac import sws_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mac_req_t          req,
	input  logic              clr,
	output logic [ScoreW-1:0] score
);
	logic [ScoreW-1:0] score_q;
	logic [32:0]       prod;
	logic [ScoreW:0]   sum;
	logic [ScoreW-1:0] prod_w;

	assign prod = 33'(req.weight) * 33'(decay_lookup(req.count));
	assign prod_w = ScoreW'(prod);
	assign sum = {1'b0, score_q} + {1'b0, prod_w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
		end else if (clr) begin
			score_q <= '0;
		end else if (req.go) begin
			if (req.sub) begin
				score_q <= (score_q > prod_w) ? score_q - prod_w : '0;
			end else begin
				score_q <= sum[ScoreW] ? ScoreMax : sum[ScoreW-1:0];
			end
		end
	end

	assign score = score_q;
endmodule

[rtl/sliding_window_snippet_scorer.sv]
// Top level of the sliding-window snippet scorer: sequencer, token ring and best tracking.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | term_slot, start_offset, end_offset, last
//  out     | out_valid | out_stall | best_begin, best_end, found
//  cfg     | cfg_we    | -         | cfg_index, cfg_data
//
// When nothing is dropped, a token steps through accept, check, add or skip, and
// output. Each dropped old token adds a drop step and a further check of the next
// oldest; the single score unit and the single ring read port set this.
// While a drop updates the score, the ring already reads the next oldest token.
// Reset clears all control and score state; the ring needs no clearing.
// While a result waits in its output register under stall, the input is stalled too.
module sliding_window_snippet_scorer import sws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  term_slot,
	input  logic [23:0] start_offset,
	input  logic [23:0] end_offset,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [19:0] best_begin,
	output logic [20:0] best_end,
	output logic        found
);
	state_t state_q, state_d;

	logic [15:0] max_width_q;
	logic [15:0] weight_q [NumTerms];

	// Ring of token slots and starts; read data registered.
	logic [26:0] ring_mem [WindowDepth];
	logic [26:0] ring_rd_q;
	logic [RingAw-1:0] rd_addr;

	logic [8:0]  count_q [NumTerms];
	logic [19:0] wbeg_q;
	logic [20:0] wend_q;
	logic [ScoreW-1:0] top_q;
	logic [19:0] top_beg_q;
	logic [20:0] top_end_q;

	// Captured token.
	logic [2:0]  slot_q;
	logic [23:0] start_q;
	logic [23:0] stop_q;
	logic        last_q;

	logic        ov_q;
	logic [19:0] ob_q;
	logic [20:0] oe_q;
	logic        of_q;

	logic        chk_q;       // a best check is due after the score update
	mac_req_t    req;
	logic        clr;
	logic [ScoreW-1:0] score;

	logic [2:0]  drop_slot;
	logic [23:0] drop_start;
	logic        drop_term;
	logic        add_term;
	logic        fits_old;
	logic        fits_new;
	logic        empty;
	logic        full;
	logic [24:0] span;

	sws_mac u_mac (.clk(clk), .arst_n(arst_n), .req(req), .clr(clr), .score(score));

	assign drop_slot = ring_rd_q[26:24];
	assign drop_start = ring_rd_q[23:0];
	assign drop_term = (drop_slot < 3'(NumTerms)) && (count_q[drop_slot] != 9'd0);
	assign add_term = slot_q < 3'(NumTerms);
	assign empty = (21'(wbeg_q) == wend_q);
	assign full = (wend_q - 21'(wbeg_q)) >= 21'(WindowDepth);
	assign span = {1'b0, stop_q} - {1'b0, drop_start};
	assign fits_old = (stop_q >= drop_start) && (span <= 25'(max_width_q));
	assign fits_new = (stop_q >= start_q) && ((stop_q - start_q) <= 24'(max_width_q));

	// A drop moves the oldest index on, so the read follows it in the same cycle.
	assign rd_addr = (state_q == ST_DROP) ? wbeg_q[RingAw-1:0] + RingAw'(1)
		: wbeg_q[RingAw-1:0];

	assign in_stall = (state_q != ST_IDLE) || (ov_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_width_q <= 16'd200;
			for (int i = 0; i < NumTerms; i++) weight_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CfgMaxWidth) begin
				max_width_q <= cfg_data;
			end else if (cfg_index <= 3'(NumTerms)) begin
				weight_q[cfg_index - 3'd1] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADD) begin
			ring_mem[wend_q[RingAw-1:0]] <= {slot_q, start_q};
		end
		ring_rd_q <= ring_mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		req = '0;
		clr = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !in_stall) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (wend_q == 21'(MaxTokens)) state_d = ST_OUT;
				else if (full) state_d = ST_DROP;
				else if (empty) state_d = fits_new ? ST_ADD : ST_SKIP;
				else if (fits_old) state_d = ST_ADD;
				else state_d = ST_DROP;
			end
			ST_DROP: begin
				req.go = drop_term;
				req.sub = 1'b1;
				req.weight = weight_q[drop_slot];
				req.count = count_q[drop_slot];
				state_d = ST_CHECK;
			end
			ST_ADD: begin
				req.go = add_term;
				req.weight = weight_q[slot_q];
				req.count = count_q[slot_q] + 9'd1;
				state_d = ST_OUT;
			end
			ST_SKIP: state_d = ST_OUT;
			ST_OUT: begin
				clr = last_q;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < NumTerms; i++) count_q[i] <= '0;
			wbeg_q <= '0;
			wend_q <= '0;
			top_q <= '0;
			top_beg_q <= '0;
			top_end_q <= '0;
			ov_q <= 1'b0;
			chk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			// The best check sees the score in the cycle after its update.
			chk_q <= (state_q == ST_DROP) || (state_q == ST_ADD) || (state_q == ST_SKIP);
			if (chk_q && score > top_q && !(state_q == ST_OUT && last_q)) begin
				top_q <= score;
				top_beg_q <= wbeg_q;
				top_end_q <= wend_q;
			end
			unique case (state_q)
				ST_DROP: begin
					if (drop_term) count_q[drop_slot] <= count_q[drop_slot] - 9'd1;
					wbeg_q <= wbeg_q + 20'd1;
				end
				ST_ADD: begin
					if (add_term) count_q[slot_q] <= count_q[slot_q] + 9'd1;
					wend_q <= wend_q + 21'd1;
				end
				ST_SKIP: begin
					wbeg_q <= wbeg_q + 20'd1;
					wend_q <= wend_q + 21'd1;
				end
				ST_OUT: begin
					if (last_q) begin
						// Best compare of the final step is folded in here.
						ov_q <= 1'b1;
						if (chk_q && score > top_q) begin
							ob_q <= wbeg_q;
							oe_q <= wend_q;
							of_q <= 1'b1;
						end else begin
							ob_q <= top_beg_q;
							oe_q <= top_end_q;
							of_q <= top_q != '0;
						end
						for (int i = 0; i < NumTerms; i++) count_q[i] <= '0;
						wbeg_q <= '0;
						wend_q <= '0;
						top_q <= '0;
						top_beg_q <= '0;
						top_end_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && !in_stall) begin
			slot_q <= term_slot;
			start_q <= start_offset;
			stop_q <= end_offset;
			last_q <= last;
		end
	end

	assign out_valid = ov_q;
	assign best_begin = ob_q;
	assign best_end = oe_q;
	assign found = of_q;

	// The window never holds more tokens than the ring.
	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(wend_q - 21'(wbeg_q)) <= 21'(WindowDepth))
		else $error("window exceeds ring depth");

	// No new token enters while a result is held under stall.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |-> in_stall)
		else $error("input taken while result stalled");

	// A result is only raised from the output step of a final token.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q == ST_OUT && last_q))
		else $error("result raised outside output step");
endmodule
